/* src/deq_pkg.sv */
// shared types and codes for the double-ended queue
// no dependencies
package deq_pkg;

    localparam int VAL_W = 64;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;
    localparam logic [2:0] MODE_PEEK       = 3'd5;

    typedef logic [2:0] op_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_CLEAR      = 3'd4;
    localparam op_t OP_PEEK       = 3'd5;

    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

/* src/deq_front.sv */
// command intake: takes a transaction and classifies its mode into an operation
// depends on deq_pkg
module deq_front (
    input  logic                              start,
    input  logic [2:0]                        mode,
    input  logic signed [deq_pkg::VAL_W-1:0]  value,
    input  logic                              q_full,
    output logic                              busy,
    output logic                              q_push,
    output deq_pkg::cmd_t                     q_cmd
);
    import deq_pkg::*;

    op_t op;

    always_comb
    begin
        case (mode)
            MODE_PUSH_FRONT: op = OP_PUSH_FRONT;
            MODE_PUSH_BACK:  op = OP_PUSH_BACK;
            MODE_POP_FRONT:  op = OP_POP_FRONT;
            MODE_POP_BACK:   op = OP_POP_BACK;
            MODE_CLEAR:      op = OP_CLEAR;
            default:         op = OP_PEEK;
        endcase
    end

    assign busy        = q_full;
    assign q_push      = start && !q_full;
    assign q_cmd.op    = op;
    assign q_cmd.value = value;

endmodule

/* src/deq_queue.sv */
// two-entry command queue between intake and execution
// depends on deq_pkg
module deq_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  deq_pkg::cmd_t cmd_in,
    input  logic          pop,
    output deq_pkg::cmd_t cmd_out,
    output logic          empty,
    output logic          full
);
    import deq_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* src/deq_back.sv */
// execution: ring store, head/tail pointers, end caches and result registers
// depends on deq_pkg
module deq_back #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  deq_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              done,
    output logic signed [deq_pkg::VAL_W-1:0]  popped_value,
    output logic                              pop_empty,
    output logic signed [deq_pkg::VAL_W-1:0]  front_value,
    output logic signed [deq_pkg::VAL_W-1:0]  back_value,
    output logic [CW-1:0]                     fill_count,
    output logic                              is_empty,
    output logic                              push_dropped
);
    import deq_pkg::*;

    localparam logic ST_EXEC = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    logic             state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [VAL_W-1:0] front_reg, front_next;
    logic [VAL_W-1:0] back_reg, back_next;
    logic             rd_front_reg, rd_front_next;
    logic             done_reg, done_next;

    logic [VAL_W-1:0] popped_reg, popped_next;
    logic             pop_empty_reg, pop_empty_next;
    logic [VAL_W-1:0] front_out_reg, front_out_next;
    logic [VAL_W-1:0] back_out_reg, back_out_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             is_empty_reg, is_empty_next;
    logic             dropped_reg, dropped_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             need_read;
    logic             take;
    logic [AW-1:0]    head_inc, head_dec, tail_inc, tail_dec;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_SLOT : tail_reg - 1'b1;

    assign take  = (state_reg == ST_EXEC) && !q_empty;
    assign q_pop = take;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        rd_front_next  = rd_front_reg;
        done_next      = 1'b0;
        popped_next    = popped_reg;
        pop_empty_next = pop_empty_reg;
        front_out_next = front_out_reg;
        back_out_next  = back_out_reg;
        fill_next      = fill_reg;
        is_empty_next  = is_empty_reg;
        dropped_next   = dropped_reg;
        wr_en          = 1'b0;
        wr_addr        = head_dec;
        rd_addr        = head_inc;
        need_read      = 1'b0;

        if (take)
        begin
            popped_next    = '1;
            pop_empty_next = 1'b0;
            dropped_next   = 1'b0;
            case (q_cmd.op)
                OP_PUSH_FRONT:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        front_next = q_cmd.value;
                        if (count_reg == '0)
                        begin
                            back_next = q_cmd.value;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_en     = 1'b1;
                        wr_addr   = tail_inc;
                        back_next = q_cmd.value;
                        if (count_reg == '0)
                        begin
                            front_next = q_cmd.value;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        pop_empty_next = 1'b1;
                    end
                    else
                    begin
                        popped_next   = front_reg;
                        head_next     = head_inc;
                        rd_addr       = head_inc;
                        rd_front_next = 1'b1;
                        count_next    = count_reg - 1'b1;
                        need_read     = (count_reg != CW'(1));
                    end
                end
                OP_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        pop_empty_next = 1'b1;
                    end
                    else
                    begin
                        popped_next   = back_reg;
                        tail_next     = tail_dec;
                        rd_addr       = tail_dec;
                        rd_front_next = 1'b0;
                        count_next    = count_reg - 1'b1;
                        need_read     = (count_reg != CW'(1));
                    end
                end
                OP_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = LAST_SLOT;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase

            fill_next      = count_next;
            is_empty_next  = (count_next == '0);
            front_out_next = (count_next == '0) ? '1 : front_next;
            back_out_next  = (count_next == '0) ? '1 : back_next;
            if (need_read)
            begin
                state_next = ST_READ;
            end
            else
            begin
                done_next = 1'b1;
            end
        end
        else if (state_reg == ST_READ)
        begin
            if (rd_front_reg)
            begin
                front_next     = rd_data_reg;
                front_out_next = rd_data_reg;
            end
            else
            begin
                back_next     = rd_data_reg;
                back_out_next = rd_data_reg;
            end
            done_next  = 1'b1;
            state_next = ST_EXEC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EXEC;
            head_reg  <= '0;
            tail_reg  <= LAST_SLOT;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg     <= front_next;
        back_reg      <= back_next;
        rd_front_reg  <= rd_front_next;
        popped_reg    <= popped_next;
        pop_empty_reg <= pop_empty_next;
        front_out_reg <= front_out_next;
        back_out_reg  <= back_out_next;
        fill_reg      <= fill_next;
        is_empty_reg  <= is_empty_next;
        dropped_reg   <= dropped_next;
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign pop_empty    = pop_empty_reg;
    assign front_value  = front_out_reg;
    assign back_value   = back_out_reg;
    assign fill_count   = fill_reg;
    assign is_empty     = is_empty_reg;
    assign push_dropped = dropped_reg;

endmodule

/* src/double_ended_queue.sv */
// double-ended queue top level: intake, two-entry command queue, execution
// depends on deq_pkg, deq_front, deq_queue, deq_back
//
//   channel   handshake       fields
//   -------   -------------   ---------------------------------------------------
//   command   start / busy    mode, value
//   result    done (strobe)   popped_value, pop_empty, front_value, back_value,
//                             fill_count, is_empty, push_dropped
//
// execution takes one transaction per cycle while commands wait, plus a read state for a pop
// that leaves the queue non-empty (one ring store read refills the front or back cache).
// commands pass through the command queue; done and the results are registered.
// busy rises while the two-entry command queue is full.
// reset clears pointers and count; the ring store needs no clearing pass.
// results are shown for one cycle with done; the receiver cannot stall.
module double_ended_queue #(
    parameter  int DEPTH = 1024,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        mode,
    input  logic signed [deq_pkg::VAL_W-1:0]  value,
    output logic                              done,
    output logic signed [deq_pkg::VAL_W-1:0]  popped_value,
    output logic                              pop_empty,
    output logic signed [deq_pkg::VAL_W-1:0]  front_value,
    output logic signed [deq_pkg::VAL_W-1:0]  back_value,
    output logic [CW-1:0]                     fill_count,
    output logic                              is_empty,
    output logic                              push_dropped
);
    import deq_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    cmd_t cmd_in;
    cmd_t cmd_out;

    deq_front u_front (
        .start  (start),
        .mode   (mode),
        .value  (value),
        .q_full (q_full),
        .busy   (busy),
        .q_push (q_push),
        .q_cmd  (cmd_in)
    );

    deq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (cmd_in),
        .pop     (q_pop),
        .cmd_out (cmd_out),
        .empty   (q_empty),
        .full    (q_full)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (cmd_out),
        .q_pop        (q_pop),
        .done         (done),
        .popped_value (popped_value),
        .pop_empty    (pop_empty),
        .front_value  (front_value),
        .back_value   (back_value),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .push_dropped (push_dropped)
    );

`ifndef SYNTHESIS
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && pop_empty |-> (popped_value == '1) && !push_dropped && is_empty)
        else $error("pop on empty queue reported wrongly");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && push_dropped |-> (fill_count == CW'(DEPTH)))
        else $error("push dropped while queue not full");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_empty |-> (front_value == '1) && (back_value == '1))
        else $error("empty queue shows end values");
`endif

endmodule

/* tb/testbench.sv */
// self-checking testbench for double_ended_queue: directed and random transactions
// with a shadow ring-buffer deque predicting every result
// depends on deq_pkg and double_ended_queue
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int QUEUE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 28;
    localparam int DRAIN_WAIT  = 20;
    localparam op_t OP_SPARE_6 = 3'd6;
    localparam op_t OP_SPARE_7 = 3'd7;
    localparam logic signed [VAL_W-1:0] NO_ELEMENT = '1;
    localparam logic signed [VAL_W-1:0] MAX_VALUE  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] MIN_VALUE  = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct {
        logic signed [VAL_W-1:0] popped;
        logic                    pop_empty;
        logic signed [VAL_W-1:0] front;
        logic signed [VAL_W-1:0] back;
        logic [10:0]             count;
        logic                    empty;
        logic                    dropped;
    } deq_outcome_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [2:0]              mode = OP_PEEK;
    logic signed [VAL_W-1:0] value = '0;
    logic                    busy;
    logic                    done;
    logic signed [VAL_W-1:0] popped_value;
    logic                    pop_empty;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [10:0]             fill_count;
    logic                    is_empty;
    logic                    push_dropped;

    cmd_t         backlog[$];
    deq_outcome_t outcomes_due[$];

    logic signed [VAL_W-1:0] shadow_ring [QUEUE_DEPTH];
    logic [9:0]              shadow_head = '0;
    logic [10:0]             shadow_count = '0;

    int  plan_count = 0;
    int  issued = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  taken = 1'b0;

    double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .pop_empty    (pop_empty),
        .front_value  (front_value),
        .back_value   (back_value),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .push_dropped (push_dropped)
    );

    always #6 clk = ~clk;

    function automatic deq_outcome_t shadow_step(op_t m, logic signed [VAL_W-1:0] v);
        deq_outcome_t r;
        logic [9:0]   slot;
        r.popped    = NO_ELEMENT;
        r.pop_empty = 1'b0;
        r.dropped   = 1'b0;
        case (m)
            OP_PUSH_FRONT:
                if (shadow_count == QUEUE_DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_ring[shadow_head] = v;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_PUSH_BACK:
                if (shadow_count == QUEUE_DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    slot = shadow_head + shadow_count[9:0];
                    shadow_ring[slot] = v;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    r.pop_empty = 1'b1;
                else
                begin
                    r.popped = shadow_ring[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            OP_POP_BACK:
                if (shadow_count == 0)
                    r.pop_empty = 1'b1;
                else
                begin
                    slot = shadow_head + shadow_count[9:0] - 1'b1;
                    r.popped = shadow_ring[slot];
                    shadow_count = shadow_count - 1'b1;
                end
            OP_CLEAR:
            begin
                shadow_count = '0;
                shadow_head = '0;
            end
            default:
                ;
        endcase
        if (shadow_count == 0)
        begin
            r.front = NO_ELEMENT;
            r.back  = NO_ELEMENT;
        end
        else
        begin
            slot = shadow_head + shadow_count[9:0] - 1'b1;
            r.front = shadow_ring[shadow_head];
            r.back  = shadow_ring[slot];
        end
        r.count = shadow_count;
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return MAX_VALUE;
            1: return MIN_VALUE;
            2: return NO_ELEMENT;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic plan(op_t m, logic signed [VAL_W-1:0] v);
        cmd_t c;
        c.op = m;
        c.value = v;
        backlog.insert(backlog.size(), c);
        case (m)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (plan_count < QUEUE_DEPTH)
                    plan_count++;
            OP_POP_FRONT, OP_POP_BACK:
                if (plan_count > 0)
                    plan_count--;
            OP_CLEAR:
                plan_count = 0;
            default:
                ;
        endcase
    endtask

    task automatic check_field(string field, logic signed [VAL_W-1:0] want,
                               logic signed [VAL_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // result check first, then prediction of the transaction taken at this edge
    always @(posedge clk)
    begin : monitor
        deq_outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual count %0d",
                             $time, fill_count);
                end
                else
                begin
                    want = outcomes_due[0];
                    outcomes_due.delete(0);
                    check_field("popped_value", want.popped, popped_value);
                    check_field("pop_empty", want.pop_empty, pop_empty);
                    check_field("front_value", want.front, front_value);
                    check_field("back_value", want.back, back_value);
                    check_field("fill_count", want.count, fill_count);
                    check_field("is_empty", want.empty, is_empty);
                    check_field("push_dropped", want.dropped, push_dropped);
                end
            end
            if (start && !busy)
            begin
                outcomes_due.insert(outcomes_due.size(), shadow_step(mode, value));
                taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        cmd_t nxt;
        if (rst_n && (!start || taken))
        begin
            taken = 1'b0;
            if (backlog.size() != 0 &&
                ((issued >= 700 && issued < 1100) || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = backlog[0];
                backlog.delete(0);
                start <= 1'b1;
                mode  <= nxt.op;
                value <= nxt.value;
                issued++;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int r;
        // directed part
        plan(OP_PEEK, rand_value());
        plan(OP_POP_FRONT, rand_value());
        plan(OP_POP_BACK, rand_value());
        plan(OP_PUSH_FRONT, MAX_VALUE);
        plan(OP_PUSH_BACK, MIN_VALUE);
        plan(OP_PUSH_FRONT, '0);
        plan(OP_PUSH_BACK, NO_ELEMENT);
        plan(OP_PEEK, rand_value());
        plan(OP_SPARE_6, rand_value());
        plan(OP_SPARE_7, rand_value());
        plan(OP_POP_FRONT, rand_value());
        plan(OP_POP_BACK, rand_value());
        plan(OP_POP_FRONT, rand_value());
        plan(OP_POP_BACK, rand_value());
        plan(OP_POP_BACK, rand_value());
        plan(OP_PUSH_BACK, {(VAL_W/2){2'b01}});
        plan(OP_PUSH_BACK, {(VAL_W/2){2'b10}});
        plan(OP_CLEAR, rand_value());
        plan(OP_POP_FRONT, rand_value());
        plan(OP_CLEAR, rand_value());
        plan(OP_PUSH_FRONT, 64'sd1);
        plan(OP_POP_BACK, rand_value());

        // mixed operations at low occupancy
        repeat (250)
            plan(op_t'($urandom_range(0, 7)), rand_value());

        // fill to capacity from both ends so the ring wraps
        while (plan_count < QUEUE_DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 48)
                plan(OP_PUSH_FRONT, rand_value());
            else if (r < 96)
                plan(OP_PUSH_BACK, rand_value());
            else if (r < 98)
                plan($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, rand_value());
            else
                plan($urandom_range(0, 1) ? OP_PEEK : OP_SPARE_7, rand_value());
        end

        // hover at full: pushes mostly dropped
        repeat (40)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                plan($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_value());
            else if (r < 90)
                plan($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, rand_value());
            else
                plan(OP_PEEK, rand_value());
        end
        plan(OP_CLEAR, rand_value());

        repeat (300)
            plan(op_t'($urandom_range(0, 7)), rand_value());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (backlog.size() != 0 || start)
            @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && outcomes_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
